// ===== hw/rtl/tcprt_pkg.sv =====
// shared types and constants for the tcp reassembly interval tracker
// no dependencies; imported by every module of the block
package tcprt_pkg;

    localparam int MAX_RANGES = 16;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);

    localparam logic [20:0] WINDOW_CAP = 21'h100000;

    localparam logic CMD_PUT    = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_OLD      = 3'd2;
    localparam logic [2:0] ST_NO_SPACE = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    localparam logic REG_WINDOW = 1'b0;
    localparam logic REG_ISEQ   = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [31:0] segment_seq;
        logic [15:0] byte_count;
    } item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] bytes_done;
        logic [19:0] ready_bytes;
        logic [31:0] delivered_total;
    } result_t;

    // classified word handed from front to back
    typedef struct packed {
        logic        is_remove;
        logic        zero_len;
        logic [31:0] seq;
        logic [15:0] cnt;
    } work_t;

    typedef struct packed {
        logic        clear;
        logic [31:0] head_init;
        logic [20:0] window;
    } cfg_t;

endpackage

// ===== hw/rtl/tcp_reassembly_interval_tracker.sv =====
// top level of the tcp reassembly interval tracker: config registers,
// front queue, range engine and result queue; depends on tcprt_pkg,
// tcprt_front and tcprt_engine
//
// usage: words go in through push/full (cmd 0 puts a received range,
// cmd 1 removes in-order bytes); each word yields exactly one result word
// on the empty/pop side, in order. registers: window_bytes at 0x0,
// initial_sequence at 0x4; writing initial_sequence empties the table.
// write registers only while the block is idle.
// zero-length, old, no-space and remove words go from the idle state of the
// engine straight to the result; a put first scans the table for the entries
// ahead of it and those it touches and, if it merges entries, packs the table,
// both one entry per cycle in the engine. one word is worked at a time.
// reset empties both queues and the table, head sequence 0, window 65536.
// a stalled receiver fills the two-word result queue, then the engine
// holds, then the two-word input queue fills and full rises.
module tcp_reassembly_interval_tracker
    import tcprt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    input  item_t       item,
    output logic        full,
    output logic        empty,
    output result_t     result,
    input  logic        pop
);

    logic [20:0] window_reg;
    logic [31:0] iseq_reg;
    logic        cfg_wr;
    cfg_t        cfg;
    logic        work_valid;
    work_t       work;
    logic        work_ready;
    logic        res_valid;
    result_t     res;
    logic        res_ready;

    result_t     oq_reg [2];
    logic        oq_wr_reg;
    logic        oq_rd_reg;
    logic [1:0]  oq_count_reg;
    logic        oq_push;
    logic        oq_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_ISEQ) ? iseq_reg : {11'd0, window_reg};

    assign cfg.clear     = cfg_wr && (paddr[2] == REG_ISEQ);
    assign cfg.head_init = pwdata;
    assign cfg.window    = window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= 21'd65536;
            iseq_reg   <= 32'd0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_WINDOW)
            begin
                window_reg <= pwdata[20:0];
            end
            else
            begin
                iseq_reg <= pwdata;
            end
        end
    end

    tcprt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .item       (item),
        .full       (full),
        .work_valid (work_valid),
        .work       (work),
        .work_ready (work_ready)
    );

    tcprt_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .work_valid (work_valid),
        .work       (work),
        .work_ready (work_ready),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // result queue, two words
    assign res_ready = (oq_count_reg != 2'd2);
    assign oq_push   = res_valid && res_ready;
    assign empty     = (oq_count_reg == 2'd0);
    assign oq_pop    = pop && !empty;
    assign result    = oq_reg[oq_rd_reg];

    always_ff @(posedge clk)
    begin
        if (oq_push)
        begin
            oq_reg[oq_wr_reg] <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg    <= 1'b0;
            oq_rd_reg    <= 1'b0;
            oq_count_reg <= 2'd0;
        end
        else
        begin
            if (oq_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (oq_pop)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            oq_count_reg <= oq_count_reg + {1'b0, oq_push} - {1'b0, oq_pop};
        end
    end

endmodule

// ===== hw/rtl/tcprt_front.sv =====
// front part: two-word input queue and command classification
// depends on tcprt_pkg
module tcprt_front
    import tcprt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t item,
    output logic  full,
    output logic  work_valid,
    output work_t work,
    input  logic  work_ready
);

    item_t       mem_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        do_push;
    logic        do_pop;
    item_t       head;

    assign full     = (count_reg == 2'd2);
    assign do_push  = push && !full;
    assign work_valid = (count_reg != 2'd0);
    assign do_pop   = work_valid && work_ready;
    assign head     = mem_reg[rd_ptr_reg];

    assign work.is_remove = (head.cmd == CMD_REMOVE);
    assign work.zero_len  = (head.byte_count == 16'd0);
    assign work.seq       = head.segment_seq;
    assign work.cnt       = head.byte_count;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== hw/rtl/tcprt_engine.sv =====
// back part: range table and the put/remove sequencer, one entry per cycle
// depends on tcprt_pkg
module tcprt_engine
    import tcprt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    work_valid,
    input  work_t   work,
    output logic    work_ready,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    typedef enum logic [2:0] {
        S_IDLE, S_FIRST, S_LAST, S_MERGE, S_PACK, S_INSERT, S_REFRESH, S_DONE
    } state_t;

    state_t             state_reg;
    logic [31:0]        start_reg [MAX_RANGES];
    logic [19:0]        len_reg   [MAX_RANGES];
    logic [CNT_W-1:0]   count_reg;
    logic [31:0]        head_reg;
    logic [19:0]        merged_reg;
    logic [31:0]        cum_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   first_reg;
    logic [CNT_W-1:0]   drop_reg;
    logic [31:0]        s_reg;
    logic [31:0]        e_reg;
    logic [15:0]        len_in_reg;
    logic [31:0]        first_off_reg;
    logic [31:0]        le_reg;
    result_t            res_reg;

    logic [31:0] cur_off;
    logic [31:0] cur_end;
    logic        ptr_in;
    logic [31:0] put_off;
    logic [20:0] win;
    logic        no_space;
    logic [19:0] rm_n;
    logic [19:0] rm_take;
    logic [31:0] ns;
    logic [31:0] ne;

    assign work_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res        = res_reg;

    always_comb
    begin
        cur_off  = start_reg[ptr_reg[IDX_W-1:0]] - head_reg;
        cur_end  = cur_off + {12'd0, len_reg[ptr_reg[IDX_W-1:0]]};
        ptr_in   = (ptr_reg < count_reg);
        put_off  = work.seq - head_reg;
        win      = (cfg.window > WINDOW_CAP) ? WINDOW_CAP : cfg.window;
        no_space = ({1'b0, put_off} + {17'd0, work.cnt}) >= {12'd0, win};
        rm_n     = ({4'd0, work.cnt} < merged_reg) ? {4'd0, work.cnt} : merged_reg;
        rm_take  = (rm_n > len_reg[0]) ? len_reg[0] : rm_n;
        ns       = (first_off_reg < s_reg) ? first_off_reg : s_reg;
        ne       = (le_reg > e_reg) ? le_reg : e_reg;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && work_valid && work.is_remove && !work.zero_len
            && rm_n != 20'd0 && count_reg != '0)
        begin
            if (rm_take == len_reg[0])
            begin
                for (int i = 0; i < MAX_RANGES - 1; i++)
                begin
                    start_reg[i] <= start_reg[i+1];
                    len_reg[i]   <= len_reg[i+1];
                end
            end
            else
            begin
                start_reg[0] <= start_reg[0] + {12'd0, rm_take};
                len_reg[0]   <= len_reg[0] - rm_take;
            end
        end
        else if (state_reg == S_MERGE)
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (CNT_W'(i) == first_reg)
                begin
                    start_reg[i] <= head_reg + ns;
                    len_reg[i]   <= 20'(ne - ns);
                end
            end
        end
        else if (state_reg == S_PACK && drop_reg != '0)
        begin
            // close the gap just above the merged entry
            for (int i = 0; i < MAX_RANGES - 1; i++)
            begin
                if (CNT_W'(i) > first_reg)
                begin
                    start_reg[i] <= start_reg[i+1];
                    len_reg[i]   <= len_reg[i+1];
                end
            end
        end
        else if (state_reg == S_INSERT && count_reg < CNT_W'(MAX_RANGES))
        begin
            for (int i = 0; i < MAX_RANGES; i++)
            begin
                if (CNT_W'(i) == first_reg)
                begin
                    start_reg[i] <= head_reg + s_reg;
                    len_reg[i]   <= {4'd0, len_in_reg};
                end
                else if (i > 0 && CNT_W'(i) > first_reg)
                begin
                    start_reg[i] <= start_reg[i-1];
                    len_reg[i]   <= len_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= 32'd0;
            merged_reg    <= 20'd0;
            cum_reg       <= 32'd0;
            ptr_reg       <= '0;
            first_reg     <= '0;
            drop_reg      <= '0;
            s_reg         <= 32'd0;
            e_reg         <= 32'd0;
            len_in_reg    <= 16'd0;
            first_off_reg <= 32'd0;
            le_reg        <= 32'd0;
            res_reg       <= '0;
        end
        else if (cfg.clear)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            head_reg   <= cfg.head_init;
            merged_reg <= 20'd0;
            cum_reg    <= 32'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (work_valid)
                    begin
                        if (work.zero_len)
                        begin
                            res_reg   <= '{ST_ZERO, 16'd0, merged_reg, cum_reg};
                            state_reg <= S_DONE;
                        end
                        else if (work.is_remove)
                        begin
                            state_reg <= S_DONE;
                            if (rm_n != 20'd0 && count_reg != '0)
                            begin
                                head_reg   <= head_reg + {12'd0, rm_take};
                                merged_reg <= merged_reg - rm_take;
                                res_reg    <= '{ST_OK, rm_take[15:0],
                                                merged_reg - rm_take, cum_reg};
                                if (rm_take == len_reg[0])
                                begin
                                    count_reg <= count_reg - 1'b1;
                                end
                            end
                            else
                            begin
                                res_reg <= '{ST_OK, 16'd0, merged_reg, cum_reg};
                            end
                        end
                        else if (put_off[31])
                        begin
                            res_reg   <= '{ST_OLD, 16'd0, merged_reg, cum_reg};
                            state_reg <= S_DONE;
                        end
                        else if (no_space)
                        begin
                            res_reg   <= '{ST_NO_SPACE, 16'd0, merged_reg, cum_reg};
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            s_reg      <= put_off;
                            e_reg      <= put_off + {16'd0, work.cnt};
                            len_in_reg <= work.cnt;
                            ptr_reg    <= '0;
                            state_reg  <= S_FIRST;
                        end
                    end
                end
                S_FIRST:
                begin
                    if (ptr_in && cur_end < s_reg)
                    begin
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else
                    begin
                        first_reg <= ptr_reg;
                        state_reg <= S_LAST;
                    end
                end
                S_LAST:
                begin
                    if (ptr_in && cur_off <= e_reg)
                    begin
                        if (ptr_reg == first_reg)
                        begin
                            first_off_reg <= cur_off;
                        end
                        le_reg  <= cur_end;
                        ptr_reg <= ptr_reg + 1'b1;
                    end
                    else if (ptr_reg > first_reg)
                    begin
                        state_reg <= S_MERGE;
                    end
                    else
                    begin
                        state_reg <= S_INSERT;
                    end
                end
                S_MERGE:
                begin
                    drop_reg  <= ptr_reg - first_reg - 1'b1;
                    state_reg <= S_PACK;
                end
                S_PACK:
                begin
                    if (drop_reg == '0)
                    begin
                        state_reg <= S_REFRESH;
                    end
                    else
                    begin
                        drop_reg  <= drop_reg - 1'b1;
                        count_reg <= count_reg - 1'b1;
                    end
                end
                S_INSERT:
                begin
                    if (count_reg >= CNT_W'(MAX_RANGES))
                    begin
                        res_reg   <= '{ST_FULL, 16'd0, merged_reg, cum_reg};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                        state_reg <= S_REFRESH;
                    end
                end
                S_REFRESH:
                begin
                    if (count_reg != '0 && start_reg[0] == head_reg)
                    begin
                        merged_reg <= len_reg[0];
                        cum_reg    <= cum_reg + {12'd0, len_reg[0]} - {12'd0, merged_reg};
                        res_reg    <= '{ST_OK, len_in_reg, len_reg[0],
                                        cum_reg + {12'd0, len_reg[0]} - {12'd0, merged_reg}};
                    end
                    else
                    begin
                        res_reg <= '{ST_OK, len_in_reg, merged_reg, cum_reg};
                    end
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (res_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RANGES))
        else $error("range count above table size");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.clear |=> (count_reg == '0 && merged_reg == 20'd0))
        else $error("table not cleared by sequence write");

    a_nonok_no_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_reg.status != ST_OK) |-> res_reg.bytes_done == 16'd0)
        else $error("failed step reports bytes");

    a_scan_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRST || state_reg == S_LAST) |-> ptr_reg <= count_reg)
        else $error("scan pointer past table end");

endmodule
